FILE: hdl/sbc_pkg.sv
// Shared constants and types for the Simeck bit-serial cipher.
package sbc_pkg;

	localparam int WORD_BITS = 32;
	localparam int ROUNDS    = 44;
	localparam int RK_DEPTH  = 44;
	localparam int N_RND     = (ROUNDS > RK_DEPTH) ? RK_DEPTH : ROUNDS;
	localparam int RND_W     = $clog2(N_RND);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int BLK_BITS  = 2 * WORD_BITS;
	localparam int DATA_BITS = 64;
	localparam int REG_BITS  = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = ADDR_W - 2;

	// round-constant bit sequence, consumed LSB first
	localparam logic [63:0] Z_SEQ = (WORD_BITS == 16) ? 64'h0000_0000_9A42_BB1F
	                                                  : 64'h0000_0938_BCA3_083F;

	localparam logic [REG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd4;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [RND_W-1:0]     rnd_t;
	typedef logic [BIT_W-1:0]     bit_idx_t;

	typedef struct packed {
		logic [3:0][REG_BITS-1:0] key;
		logic                     decrypt;
		logic                     key_wr;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic perm;
		logic step;
		logic first_bit;
		logic low5;
	} round_ctl_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic shift;
	} key_ctl_t;

endpackage

FILE: hdl/sbc_stream_if.sv
// Valid/ready stream interfaces for cipher input and output blocks.
interface sbc_in_if;
	import sbc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] data_in;
	logic [DATA_BITS-1:0] xor_mask;
	logic                 xor_enable;
	modport source (output valid, data_in, xor_mask, xor_enable, input ready);
	modport sink   (input valid, data_in, xor_mask, xor_enable, output ready);
endinterface

interface sbc_out_if;
	import sbc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] data_out;
	modport source (output valid, data_out, input ready);
	modport sink   (input valid, data_out, output ready);
endinterface

FILE: hdl/sbc_cfg.sv
// APB register file: key words and mode.
module sbc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sbc_pkg::ADDR_W-1:0]  paddr,
	input  logic [sbc_pkg::REG_BITS-1:0] pwdata,
	output logic [sbc_pkg::REG_BITS-1:0] prdata,
	output logic                        pready,
	output sbc_pkg::cfg_t               cfg
);
	import sbc_pkg::*;

	logic [3:0][REG_BITS-1:0] key_q;
	logic                     mode_q;
	logic                     wr_en;
	logic [REG_IDX_W-1:0]     idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_KEY0: key_q[0] <= pwdata;
				REG_KEY1: key_q[1] <= pwdata;
				REG_KEY2: key_q[2] <= pwdata;
				REG_KEY3: key_q[3] <= pwdata;
				REG_MODE: mode_q   <= pwdata[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEY0: prdata = key_q[0];
			REG_KEY1: prdata = key_q[1];
			REG_KEY2: prdata = key_q[2];
			REG_KEY3: prdata = key_q[3];
			REG_MODE: prdata = {{(REG_BITS-1){1'b0}}, mode_q};
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.key     = key_q;
		cfg.decrypt = mode_q;
		cfg.key_wr  = wr_en && (idx == REG_KEY0 || idx == REG_KEY1 ||
		                        idx == REG_KEY2 || idx == REG_KEY3);
	end

endmodule

FILE: hdl/sbc_key_store.sv
// Round-key memory; the read register doubles as the key bit shifter.
module sbc_key_store (
	input  logic              clk,
	input  sbc_pkg::key_ctl_t ctl,
	input  sbc_pkg::rnd_t     waddr,
	input  sbc_pkg::rnd_t     raddr,
	input  sbc_pkg::word_t    wdata,
	output logic              kbit
);
	import sbc_pkg::*;

	word_t mem [N_RND];
	word_t rk_q;

	always_ff @(posedge clk) begin
		if (ctl.wr)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.rd)
			rk_q <= mem[raddr];
		else if (ctl.shift)
			rk_q <= {1'b0, rk_q[WORD_BITS-1:1]};
	end

	assign kbit = rk_q[0];

endmodule

FILE: hdl/sbc_round.sv
// Bit-serial Simeck round: L/R shift one bit per cycle while step is set, LSB first.
module sbc_round (
	input  logic                clk,
	input  sbc_pkg::round_ctl_t ctl,
	input  sbc_pkg::word_t      ld_l,
	input  sbc_pkg::word_t      ld_r,
	input  sbc_pkg::word_t      ld_s2,
	input  sbc_pkg::word_t      ld_s3,
	input  logic                kbit,
	output sbc_pkg::word_t      l_word,
	output sbc_pkg::word_t      r_word
);
	import sbc_pkg::*;

	word_t l_q, r_q, s2_q, s3_q;
	logic  a1, a5, nb;

	// Old L bits already consumed sit at the top of R; the wrapped
	// ones are still in the untouched part of L.
	always_comb begin
		a1 = ctl.first_bit ? l_q[WORD_BITS-1] : r_q[WORD_BITS-1];
		a5 = ctl.low5 ? l_q[WORD_BITS-5] : r_q[WORD_BITS-5];
		nb = (l_q[0] & a5) ^ a1 ^ r_q[0] ^ kbit;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			l_q  <= ld_l;
			r_q  <= ld_r;
			s2_q <= ld_s2;
			s3_q <= ld_s3;
		end else if (ctl.perm) begin
			// key schedule word rotation
			l_q  <= s2_q;
			s2_q <= s3_q;
			s3_q <= l_q;
		end else if (ctl.step) begin
			l_q <= {nb, l_q[WORD_BITS-1:1]};
			r_q <= {l_q[0], r_q[WORD_BITS-1:1]};
		end
	end

	assign l_word = l_q;
	assign r_word = r_q;

endmodule

FILE: hdl/simeck_block_cipher.sv
// Simeck block cipher top level: APB config, stream ports and sequencer.
//
// Simeck 64/128 (32-bit words, 44 rounds) computed one bit per clock, while
// the bit state runs, by a serial round unit. Each round passes a prep state,
// which fetches the round key from the key memory (or, in the key schedule,
// stores a round key and rotates the key words), and then the bit state. The
// first block after reset or any key-word write first runs the key schedule
// through the same round unit. One block is in flight at a time; a finished
// result waits in the output register while the next block is taken. The
// mode register selects decryption, which uses the reversed key order and
// needs no new key schedule.
module simeck_block_cipher (
	input  logic                         clk,
	input  logic                         arst_n,
	sbc_in_if.sink                       in_ch,
	sbc_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sbc_pkg::ADDR_W-1:0]   paddr,
	input  logic [sbc_pkg::REG_BITS-1:0] pwdata,
	output logic [sbc_pkg::REG_BITS-1:0] prdata,
	output logic                         pready
);
	import sbc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_KINIT = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_BITS  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	cfg_t       cfg;
	round_ctl_t rctl;
	key_ctl_t   kctl;

	logic [2:0]           state_q;
	logic                 keys_ready_q;
	logic                 exp_q;
	rnd_t                 rnd_q;
	bit_idx_t             bit_q;
	logic [N_RND-1:0]     zseq_q;
	logic                 out_valid_q;
	logic [DATA_BITS-1:0] out_q;
	logic [BLK_BITS-1:0]  blk_q;
	logic [BLK_BITS-1:0]  mask_q;
	logic                 mask_en_q;

	word_t l_word, r_word;
	word_t ld_l, ld_r, ld_s2, ld_s3;
	word_t blk_hi, blk_lo;
	rnd_t  raddr;
	logic  key_bit, cbit, kbit;
	logic  last_bit, last_rnd;
	logic  in_xfer, out_free;
	logic [BLK_BITS-1:0] res;

	sbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign last_bit    = (bit_q == bit_idx_t'(WORD_BITS - 1));
	assign last_rnd    = (rnd_q == rnd_t'(N_RND - 1));

	assign blk_hi = blk_q[BLK_BITS-1:WORD_BITS];
	assign blk_lo = blk_q[WORD_BITS-1:0];

	always_comb begin
		if (state_q == ST_KINIT) begin
			// preloaded so the first rotation lands on (t1, t2, t3)
			ld_l = cfg.key[0][WORD_BITS-1:0];
			ld_r = cfg.key[3][WORD_BITS-1:0];
		end else if (cfg.decrypt) begin
			ld_l = blk_lo;
			ld_r = blk_hi;
		end else begin
			ld_l = blk_hi;
			ld_r = blk_lo;
		end
		ld_s2 = cfg.key[2][WORD_BITS-1:0];
		ld_s3 = cfg.key[1][WORD_BITS-1:0];
	end

	always_comb begin
		rctl.load      = (state_q == ST_KINIT) || (state_q == ST_LOAD);
		rctl.perm      = (state_q == ST_PREP) && exp_q;
		rctl.step      = (state_q == ST_BITS);
		rctl.first_bit = (bit_q == '0);
		rctl.low5      = (bit_q < bit_idx_t'(5));
		kctl.wr        = (state_q == ST_PREP) && exp_q;
		kctl.rd        = (state_q == ST_PREP) && !exp_q;
		kctl.shift     = (state_q == ST_BITS);
	end

	assign raddr = cfg.decrypt ? (rnd_t'(N_RND - 1) - rnd_q) : rnd_q;

	sbc_key_store u_keys (
		.clk   (clk),
		.ctl   (kctl),
		.waddr (rnd_q),
		.raddr (raddr),
		.wdata (r_word),
		.kbit  (key_bit)
	);

	// schedule constant: all ones above bit 1, bit 1 clear, bit 0 from sequence
	always_comb begin
		if (bit_q == '0)
			cbit = zseq_q[0];
		else if (bit_q == bit_idx_t'(1))
			cbit = 1'b0;
		else
			cbit = 1'b1;
	end

	assign kbit = exp_q ? cbit : key_bit;

	sbc_round u_round (
		.clk    (clk),
		.ctl    (rctl),
		.ld_l   (ld_l),
		.ld_r   (ld_r),
		.ld_s2  (ld_s2),
		.ld_s3  (ld_s3),
		.kbit   (kbit),
		.l_word (l_word),
		.r_word (r_word)
	);

	always_comb begin
		res = cfg.decrypt ? {r_word, l_word} : {l_word, r_word};
		if (mask_en_q)
			res = res ^ mask_q;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			blk_q     <= in_ch.data_in[BLK_BITS-1:0];
			mask_q    <= in_ch.xor_mask[BLK_BITS-1:0];
			mask_en_q <= in_ch.xor_enable;
		end
		if (state_q == ST_DONE && out_free)
			out_q <= DATA_BITS'(res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			keys_ready_q <= 1'b0;
			exp_q        <= 1'b0;
			rnd_q        <= '0;
			bit_q        <= '0;
			zseq_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.key_wr)
				keys_ready_q <= 1'b0;
			else if (state_q == ST_BITS && last_bit && last_rnd && exp_q)
				keys_ready_q <= 1'b1;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= keys_ready_q ? ST_LOAD : ST_KINIT;
				end
				ST_KINIT: begin
					exp_q   <= 1'b1;
					rnd_q   <= '0;
					zseq_q  <= Z_SEQ[N_RND-1:0];
					state_q <= ST_PREP;
				end
				ST_LOAD: begin
					exp_q   <= 1'b0;
					rnd_q   <= '0;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					bit_q   <= '0;
					state_q <= ST_BITS;
				end
				ST_BITS: begin
					bit_q <= bit_q + bit_idx_t'(1);
					if (last_bit) begin
						if (exp_q)
							zseq_q <= {1'b0, zseq_q[N_RND-1:1]};
						if (last_rnd) begin
							if (exp_q)
								state_q <= ST_LOAD;
							else
								state_q <= ST_DONE;
						end else begin
							rnd_q   <= rnd_q + rnd_t'(1);
							state_q <= ST_PREP;
						end
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.data_out = out_q;

endmodule
